// File: sv/packed_pixel_block_cache_assert.svh
// ----------------------------------------------------------------------------
// Packed pixel block cache assertion macros
// Concurrent check macros; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_BLOCK_CACHE_ASSERT_SVH
`define PACKED_PIXEL_BLOCK_CACHE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset.
`define PPBC_CHECK(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ppbc check failed");

// Check that a condition holds in the cycle after a trigger.
`define PPBC_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("ppbc sequence check failed");

`else

`define PPBC_CHECK(label, clk, rst, cond)

`define PPBC_NEXT(label, clk, rst, trig, cond)

`endif

`endif

// File: sv/ppbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed pixel block cache package
// Sizes, register map, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package ppbc_pkg;

   localparam int BLOCK_PIXELS = 64;
   localparam int BLOCK_BITS   = $clog2(BLOCK_PIXELS);
   localparam int NUM_ENTRIES  = 16;
   localparam int ENTRY_BITS   = $clog2(NUM_ENTRIES);
   localparam int MAX_PIXELS   = 1048576;
   localparam int STORE_BITS   = $clog2(MAX_PIXELS);
   localparam int TAG_BITS     = STORE_BITS - BLOCK_BITS;
   localparam int CACHE_DEPTH  = NUM_ENTRIES * BLOCK_PIXELS;
   localparam int CACHE_BITS   = $clog2(CACHE_DEPTH);
   localparam int OFFSET_BITS  = 25;

   localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
   localparam logic [1:0] REG_PACK_SHIFT = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_LOOK,
      ST_SWEEP,
      ST_WB_RD,
      ST_WB_WR,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_ZERO,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_DONE
   } ppbc_state_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic look;
      logic sweep;
      logic wb_rd;
      logic wb_wr;
      logic fill_rd;
      logic fill_wr;
      logic zero_wr;
      logic acc_rd;
      logic acc_wr;
      logic clr_step;
      logic out_load;
   } ppbc_cmd_type;

   typedef struct packed {
      logic in_range;
      logic match_any;
      logic victim_free;
      logic victim_wb;
      logic zero_fill;
      logic cnt_last;
      logic clr_last;
   } ppbc_status_type;

   // Bit position of a pixel inside its packed byte, most significant first.
   function automatic logic [2:0] pack_pos(input logic [1:0] shift, input logic [2:0] p);
      logic [2:0] pos;
      case (shift)
         2'd0:    pos = 3'd0;
         2'd1:    pos = {~p[0], 2'b00};
         2'd2:    pos = {~p[1:0], 1'b0};
         2'd3:    pos = ~p;
         default: pos = 3'd0;
      endcase
      return pos;
   endfunction

   function automatic logic [7:0] pack_mask(input logic [1:0] shift);
      logic [7:0] m;
      case (shift)
         2'd0:    m = 8'hff;
         2'd1:    m = 8'h0f;
         2'd2:    m = 8'h03;
         2'd3:    m = 8'h01;
         default: m = 8'hff;
      endcase
      return m;
   endfunction

endpackage

// File: sv/packed_pixel_block_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed pixel block cache
// Pixel read/write front end over a clock-replacement write-back block cache.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (action, row, column, colour) with valid/ready;
//   one result per request leaves on rsp_* (pixel, in_range, hit).
//   Registers row_length, row_count and pack_shift sit at 0x0, 0x4 and 0x8
//   of the APB-style port; write them only while the block is idle.
//   An out-of-range request skips the cache; a hit reads and writes the entry.
//   A miss adds the clock sweep, a dirty write-back (read then merge per
//   pixel into the packed store) and a fill, or a zero fill of the entry
//   when the block lies above the high-water mark.
//   One request is in flight at a time; req_ready is high only when idle.
//   The result sits in an output register, so the next request is taken
//   while an earlier result still waits; a stalled rsp_ready holds the
//   controller only when a second result is ready to be registered.
//   After reset the backing store is swept to zero, one byte a cycle, all
//   1048576 bytes, before the first request is taken; configuration
//   writes are accepted throughout.
// ----------------------------------------------------------------------------
`include "packed_pixel_block_cache_assert.svh"

module packed_pixel_block_cache import ppbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [11:0] req_row,
   input  logic [11:0] req_column,
   input  logic [7:0]  req_color,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel,
   output logic        rsp_in_range,
   output logic        rsp_hit,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [12:0]     row_length_ff, row_length_in;
   logic [12:0]     row_count_ff, row_count_in;
   logic [1:0]      pack_shift_ff, pack_shift_in;
   logic            csr_write;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_pixel_ff;
   logic            rsp_in_range_ff;
   logic            rsp_hit_ff;

   ppbc_cmd_type    cmd;
   ppbc_status_type status;
   logic            out_free;
   logic [7:0]      dp_pixel;
   logic            dp_in_range;
   logic            dp_hit;

   // configuration registers: write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      pack_shift_in = pack_shift_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_ROW_LENGTH: row_length_in = pwdata[12:0];
            REG_ROW_COUNT:  row_count_in  = pwdata[12:0];
            REG_PACK_SHIFT: pack_shift_in = pwdata[1:0];
            default:        row_length_in = row_length_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ROW_LENGTH: prdata = {19'd0, row_length_ff};
         REG_ROW_COUNT:  prdata = {19'd0, row_count_ff};
         REG_PACK_SHIFT: prdata = {30'd0, pack_shift_ff};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 13'd1024;
         row_count_ff  <= 13'd768;
         pack_shift_ff <= 2'd3;
      end else begin
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         pack_shift_ff <= pack_shift_in;
      end
   end

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload until the next load
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pixel_ff    <= dp_pixel;
         rsp_in_range_ff <= dp_in_range;
         rsp_hit_ff      <= dp_hit;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel    = rsp_pixel_ff;
   assign rsp_in_range = rsp_in_range_ff;
   assign rsp_hit      = rsp_hit_ff;

   ppbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   ppbc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .row_length (row_length_ff),
      .row_count  (row_count_ff),
      .pack_shift (pack_shift_ff),
      .req_action (req_action),
      .req_row    (req_row),
      .req_column (req_column),
      .req_color  (req_color),
      .pixel      (dp_pixel),
      .in_range   (dp_in_range),
      .hit        (dp_hit)
   );

   // an out-of-range request never reports a pixel or a hit
   `PPBC_CHECK(a_range_clean, clock, reset, !rsp_valid || rsp_in_range || (rsp_pixel == 8'd0 && !rsp_hit))
   // a hit implies the request was in range
   `PPBC_CHECK(a_hit_in_range, clock, reset, !rsp_valid || !rsp_hit || rsp_in_range)
   // one request at a time: no back-to-back acceptance
   `PPBC_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

endmodule

// File: sv/ppbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed pixel block cache datapath
// Offset arithmetic, tag lookup, clock hand, pixel cache and backing store.
// ----------------------------------------------------------------------------
module ppbc_datapath import ppbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ppbc_cmd_type          cmd,
   output ppbc_status_type       status,
   input  logic [12:0]           row_length,
   input  logic [12:0]           row_count,
   input  logic [1:0]            pack_shift,
   input  logic                  req_action,
   input  logic [11:0]           req_row,
   input  logic [11:0]           req_column,
   input  logic [7:0]            req_color,
   output logic [7:0]            pixel,
   output logic                  in_range,
   output logic                  hit
);

   // captured request
   logic                   action_ff;
   logic [11:0]            row_ff;
   logic [11:0]            column_ff;
   logic [7:0]             color_ff;

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   range_ff, range_in;
   logic                   hit_ff, hit_in;
   logic [7:0]             result_ff, result_in;
   logic [ENTRY_BITS-1:0]  entry_ff, entry_in;
   logic [ENTRY_BITS-1:0]  hand_ff, hand_in;
   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic [NUM_ENTRIES-1:0] ref_ff, ref_in;
   logic [NUM_ENTRIES-1:0] dirty_ff, dirty_in;
   logic                   hw_any_ff, hw_any_in;
   logic [TAG_BITS-1:0]    hw_ff, hw_in;
   logic [BLOCK_BITS-1:0]  cnt_ff, cnt_in;
   logic [STORE_BITS-1:0]  clr_ff, clr_in;

   logic [TAG_BITS-1:0]    tag_ff [NUM_ENTRIES];

   logic [7:0]             cache_mem [CACHE_DEPTH];
   logic [7:0]             cache_rd_ff;
   logic [7:0]             store_mem [MAX_PIXELS];
   logic [7:0]             store_rd_ff;

   logic [TAG_BITS-1:0]    blk;
   logic [BLOCK_BITS-1:0]  idx;
   logic [NUM_ENTRIES-1:0] match;
   logic [ENTRY_BITS-1:0]  match_idx;
   logic                   match_any;
   logic [ENTRY_BITS-1:0]  hand_nxt;
   logic                   zero_fill;
   logic [STORE_BITS-1:0]  wb_pixel;
   logic [STORE_BITS-1:0]  fill_pixel;
   logic [STORE_BITS-1:0]  store_rd_addr;
   logic [STORE_BITS-1:0]  store_wr_addr;
   logic                   store_we;
   logic [7:0]             store_wdata;
   logic                   store_re;
   logic [CACHE_BITS-1:0]  cache_addr;
   logic                   cache_we;
   logic [7:0]             cache_wdata;
   logic                   cache_re;
   logic [2:0]             pos;
   logic [7:0]             mask;
   logic                   pix_change;

   assign blk      = offset_ff[STORE_BITS-1:BLOCK_BITS];
   assign idx      = offset_ff[BLOCK_BITS-1:0];
   assign hand_nxt = hand_ff + 1'b1;
   assign zero_fill = !hw_any_ff || (blk > hw_ff);
   assign mask     = pack_mask(pack_shift);
   assign wb_pixel   = {tag_ff[entry_ff], cnt_ff};
   assign fill_pixel = {blk, cnt_ff};
   assign pos        = pack_pos(pack_shift, cnt_ff[2:0]);
   assign pix_change = action_ff && (cache_rd_ff != color_ff);

   // tag compare across all entries, lowest index wins
   always_comb begin
      match_idx = '0;
      match_any = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == blk);
      end
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = ENTRY_BITS'(i);
            match_any = 1'b1;
         end
      end
   end

   always_comb begin
      status.in_range    = range_ff;
      status.match_any   = match_any;
      status.victim_free = !ref_ff[hand_nxt];
      status.victim_wb   = valid_ff[hand_nxt] && dirty_ff[hand_nxt];
      status.zero_fill   = zero_fill;
      status.cnt_last    = &cnt_ff;
      status.clr_last    = &clr_ff;
   end

   // memory port steering
   always_comb begin
      store_re      = cmd.wb_rd || cmd.fill_rd;
      store_rd_addr = cmd.wb_rd ? (wb_pixel >> pack_shift) : (fill_pixel >> pack_shift);
      store_wr_addr = cmd.clr_step ? clr_ff : (wb_pixel >> pack_shift);
      store_we      = cmd.clr_step || cmd.wb_wr;
      store_wdata   = cmd.clr_step ? 8'd0 :
                      ((store_rd_ff & ~(mask << pos)) | ((cache_rd_ff & mask) << pos));
      cache_re      = cmd.wb_rd || cmd.acc_rd;
      cache_addr    = (cmd.acc_rd || cmd.acc_wr) ? {entry_ff, idx} : {entry_ff, cnt_ff};
      cache_we      = cmd.zero_wr || cmd.fill_wr || (cmd.acc_wr && pix_change);
      if (cmd.fill_wr) begin
         cache_wdata = (store_rd_ff >> pos) & mask;
      end else if (cmd.acc_wr) begin
         cache_wdata = color_ff;
      end else begin
         cache_wdata = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wr_addr] <= store_wdata;
      end
      if (store_re) begin
         store_rd_ff <= store_mem[store_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_addr] <= cache_wdata;
      end
      if (cache_re) begin
         cache_rd_ff <= cache_mem[cache_addr];
      end
   end

   // next values of the control registers
   always_comb begin
      offset_in = offset_ff;
      range_in  = range_ff;
      hit_in    = hit_ff;
      result_in = result_ff;
      entry_in  = entry_ff;
      hand_in   = hand_ff;
      valid_in  = valid_ff;
      ref_in    = ref_ff;
      dirty_in  = dirty_ff;
      hw_any_in = hw_any_ff;
      hw_in     = hw_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      if (cmd.calc) begin
         offset_in = OFFSET_BITS'(row_ff * row_length) + OFFSET_BITS'(column_ff);
         range_in  = ({1'b0, row_ff} < row_count) && ({1'b0, column_ff} < row_length) &&
                     (OFFSET_BITS'(row_ff * row_length) + OFFSET_BITS'(column_ff)
                      < OFFSET_BITS'(MAX_PIXELS));
         hit_in    = 1'b0;
         result_in = 8'd0;
      end
      if (cmd.look) begin
         hit_in   = match_any;
         entry_in = match_idx;
         if (match_any) begin
            ref_in[match_idx] = 1'b1;
         end
      end
      if (cmd.sweep) begin
         hand_in = hand_nxt;
         if (ref_ff[hand_nxt]) begin
            ref_in[hand_nxt] = 1'b0;
         end else begin
            entry_in = hand_nxt;
         end
      end
      if (cmd.wb_wr || cmd.fill_wr || cmd.zero_wr) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.acc_rd && !hit_ff) begin
         valid_in[entry_ff] = 1'b1;
         ref_in[entry_ff]   = 1'b1;
         dirty_in[entry_ff] = 1'b0;
         if (zero_fill) begin
            hw_any_in = 1'b1;
            hw_in     = blk;
         end
      end
      if (cmd.acc_wr) begin
         result_in = action_ff ? 8'd0 : cache_rd_ff;
         if (pix_change) begin
            dirty_in[entry_ff] = 1'b1;
         end
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= 1'b0;
         hit_ff    <= 1'b0;
         result_ff <= 8'd0;
         entry_ff  <= '0;
         hand_ff   <= '0;
         valid_ff  <= '0;
         ref_ff    <= '0;
         dirty_ff  <= '0;
         hw_any_ff <= 1'b0;
         hw_ff     <= '0;
         cnt_ff    <= '0;
         clr_ff    <= '0;
      end else begin
         range_ff  <= range_in;
         hit_ff    <= hit_in;
         result_ff <= result_in;
         entry_ff  <= entry_in;
         hand_ff   <= hand_in;
         valid_ff  <= valid_in;
         ref_ff    <= ref_in;
         dirty_ff  <= dirty_in;
         hw_any_ff <= hw_any_in;
         hw_ff     <= hw_in;
         cnt_ff    <= cnt_in;
         clr_ff    <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      if (cmd.capture) begin
         action_ff <= req_action;
         row_ff    <= req_row;
         column_ff <= req_column;
         color_ff  <= req_color;
      end
      if (cmd.acc_rd && !hit_ff) begin
         tag_ff[entry_ff] <= blk;
      end
   end

   assign pixel    = result_ff;
   assign in_range = range_ff;
   assign hit      = hit_ff;

endmodule

// File: sv/ppbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed pixel block cache controller
// Sequences clear pass, lookup, clock sweep, write-back, fill and access.
// ----------------------------------------------------------------------------
module ppbc_ctrl import ppbc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            out_free,
   input  ppbc_status_type status,
   output ppbc_cmd_type    cmd
);

   ppbc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: state_in = ST_LOOK;
         ST_LOOK: begin
            if (!status.in_range) begin
               state_in = ST_DONE;
            end else if (status.match_any) begin
               state_in = ST_ACC_RD;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (status.victim_free) begin
               if (status.victim_wb) begin
                  state_in = ST_WB_RD;
               end else if (status.zero_fill) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_FILL_RD;
               end
            end
         end
         ST_WB_RD: state_in = ST_WB_WR;
         ST_WB_WR: begin
            if (!status.cnt_last) begin
               state_in = ST_WB_RD;
            end else if (status.zero_fill) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_FILL_RD;
            end
         end
         ST_FILL_RD: state_in = ST_FILL_WR;
         ST_FILL_WR: state_in = status.cnt_last ? ST_ACC_RD : ST_FILL_RD;
         ST_ZERO: begin
            if (status.cnt_last) state_in = ST_ACC_RD;
         end
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:   cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CALC:    cmd.calc = 1'b1;
         ST_LOOK:    cmd.look = status.in_range;
         ST_SWEEP:   cmd.sweep = 1'b1;
         ST_WB_RD:   cmd.wb_rd = 1'b1;
         ST_WB_WR:   cmd.wb_wr = 1'b1;
         ST_FILL_RD: cmd.fill_rd = 1'b1;
         ST_FILL_WR: cmd.fill_wr = 1'b1;
         ST_ZERO:    cmd.zero_wr = 1'b1;
         ST_ACC_RD:  cmd.acc_rd = 1'b1;
         ST_ACC_WR:  cmd.acc_wr = 1'b1;
         ST_DONE:    cmd.out_load = out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed pixel block cache testbench
// Drives pixel reads and writes through several image geometries and packing
// widths, predicts every response with a behavioural cache model and compares
// pixel, in_range and hit field by field, in order.
// ----------------------------------------------------------------------------
import ppbc_pkg::*;

class pixel_cache_scoreboard;
   typedef struct {
      logic [7:0] pixel;
      logic       in_range;
      logic       hit;
   } pixel_result_type;

   // image geometry and packing as the block currently holds them
   int unsigned row_length = 1024;
   int unsigned row_count  = 768;
   int unsigned pack_shift = 3;

   // cache and store mirror
   int unsigned tag_of [NUM_ENTRIES];
   bit          present [NUM_ENTRIES];
   bit          recent [NUM_ENTRIES];
   bit          modified [NUM_ENTRIES];
   bit [7:0]    line_data [CACHE_DEPTH];
   int unsigned hand;
   int          high_water = -1;
   bit [7:0]    packed_store [MAX_PIXELS];

   pixel_result_type awaited [$];
   int mismatches;

   function void set_register(logic [1:0] index, int unsigned value);
      case (index)
         REG_ROW_LENGTH: row_length = value & 32'h1fff;
         REG_ROW_COUNT:  row_count  = value & 32'h1fff;
         REG_PACK_SHIFT: pack_shift = value & 32'h3;
         default: ;
      endcase
   endfunction

   function void put_pixel(int unsigned p, bit [7:0] v);
      int unsigned bits, per, addr, sh, mask;
      bits = 8 >> pack_shift;
      per  = 1 << pack_shift;
      addr = p >> pack_shift;
      sh   = (per - 1 - (p & (per - 1))) * bits;
      mask = (1 << bits) - 1;
      if (p >= MAX_PIXELS || addr >= MAX_PIXELS) return;
      packed_store[addr] = (packed_store[addr] & ~(mask << sh)) | ((v & mask) << sh);
   endfunction

   function bit [7:0] get_pixel(int unsigned p);
      int unsigned bits, per, addr, sh, mask;
      bits = 8 >> pack_shift;
      per  = 1 << pack_shift;
      addr = p >> pack_shift;
      sh   = (per - 1 - (p & (per - 1))) * bits;
      mask = (1 << bits) - 1;
      if (p >= MAX_PIXELS || addr >= MAX_PIXELS) return 0;
      return (packed_store[addr] >> sh) & mask;
   endfunction

   function void note_request(bit action, int unsigned row, int unsigned column,
                              bit [7:0] color);
      pixel_result_type r;
      int unsigned offset, blk, idx, e;
      bit found;
      r.pixel = 0; r.in_range = 0; r.hit = 0;
      offset = row * row_length + column;
      if (row >= row_count || column >= row_length || offset >= MAX_PIXELS) begin
         awaited.push_back(r);
         return;
      end
      blk = offset / BLOCK_PIXELS;
      idx = offset % BLOCK_PIXELS;
      found = 0;
      e = 0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (!found && present[i] && tag_of[i] == blk) begin
            e = i;
            found = 1;
         end
      end
      if (found) begin
         recent[e] = 1;
      end else begin
         // second-chance sweep: step first, then skip referenced entries
         forever begin
            hand = (hand + 1) % NUM_ENTRIES;
            if (!recent[hand]) break;
            recent[hand] = 0;
         end
         e = hand;
         if (present[e] && modified[e])
            for (int i = 0; i < BLOCK_PIXELS; i++)
               put_pixel(tag_of[e] * BLOCK_PIXELS + i, line_data[e * BLOCK_PIXELS + i]);
         if (int'(blk) > high_water) begin
            high_water = blk;
            for (int i = 0; i < BLOCK_PIXELS; i++) line_data[e * BLOCK_PIXELS + i] = 0;
         end else begin
            for (int i = 0; i < BLOCK_PIXELS; i++)
               line_data[e * BLOCK_PIXELS + i] = get_pixel(blk * BLOCK_PIXELS + i);
         end
         tag_of[e] = blk;
         present[e] = 1;
         recent[e] = 1;
         modified[e] = 0;
      end
      if (action) begin
         if (line_data[e * BLOCK_PIXELS + idx] != color) begin
            line_data[e * BLOCK_PIXELS + idx] = color;
            modified[e] = 1;
         end
      end else begin
         r.pixel = line_data[e * BLOCK_PIXELS + idx];
      end
      r.in_range = 1;
      r.hit = found;
      awaited.push_back(r);
   endfunction

   function void check_result(logic [7:0] pixel, logic in_range, logic hit);
      pixel_result_type w;
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response: pixel %0h", pixel);
         return;
      end
      w = awaited.pop_front();
      if (pixel !== w.pixel || in_range !== w.in_range || hit !== w.hit) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: pixel %0h/%0h in_range %0b/%0b hit %0b/%0b (exp/got)",
                     w.pixel, pixel, w.in_range, in_range, w.hit, hit);
      end
   endfunction
endclass

module tb;
   localparam int IDLE_LIMIT = 5000000;   // several times the post-reset store clear

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_action = 0;
   logic [11:0] req_row = 0;
   logic [11:0] req_column = 0;
   logic [7:0]  req_color = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_pixel;
   logic        rsp_in_range;
   logic        rsp_hit;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   pixel_cache_scoreboard board = new();
   int idle_cycles;
   int responses_seen;
   int region_row, region_col, region_left;

   packed_pixel_block_cache uut (.*);

   always #4 clock = ~clock;

   // Watchdog: count cycles in which no request and no response moves.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Check every response taken at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_pixel, rsp_in_range, rsp_hit);
         responses_seen++;
      end
   end

   // Receiver: stall on its own pattern, with one long hold-off to back the block up.
   initial begin
      int mode, span;
      bit held;
      held = 0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 80);
         repeat (span) begin
            @(negedge clock);
            if (!held && responses_seen > 150) begin
               // hold off for a long stretch while the sender keeps offering
               held = 1;
               rsp_ready <= 0;
               repeat (400) @(negedge clock);
            end
            case (mode)
               0:       rsp_ready <= 1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic write_register(logic [1:0] index, int unsigned value);
      @(negedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      board.set_register(index, value);
   endtask

   // Offer one request and hold it until the block takes it.
   task automatic send_request(bit action, int row, int column, bit [7:0] color);
      @(negedge clock);
      req_valid <= 1;
      req_action <= action;
      req_row <= row;
      req_column <= column;
      req_color <= color;
      do @(posedge clock); while (!req_ready);
      board.note_request(action, row, column, color);
   endtask

   task automatic pause_sender();
      int gap;
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap == 0) return;
      @(negedge clock);
      req_valid <= 0;
      repeat (gap - 1) @(negedge clock);
   endtask

   // Drain all responses, then let the controller settle before touching registers.
   task automatic drain();
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly clustered accesses so that blocks are reused and evicted; some noise.
   task automatic random_burst(int count);
      int sent, burst, row, column, pick;
      bit [7:0] color;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if (region_left == 0) begin
               region_row = $urandom_range(0, board.row_count - 1);
               region_col = $urandom_range(0, board.row_length - 1);
               region_left = $urandom_range(4, 16);
            end
            region_left--;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               row = $urandom_range(0, 4095);
               column = $urandom_range(0, 4095);
            end else if (pick == 1) begin
               row = board.row_count - $urandom_range(0, 1);
               column = board.row_length - $urandom_range(0, 1);
            end else begin
               row = (region_row + $urandom_range(0, 2)) % board.row_count;
               column = (region_col + $urandom_range(0, 15)) % board.row_length;
            end
            case ($urandom_range(0, 3))
               0:       color = 8'h00;
               1:       color = 8'hff;
               default: color = $urandom_range(0, 255);
            endcase
            send_request($urandom_range(0, 1), row & 12'hfff, column & 12'hfff, color);
            sent++;
         end
         pause_sender();
      end
      @(negedge clock);
      req_valid <= 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: default geometry, 1 bit per pixel
      send_request(1, 0, 0, 8'hff);
      send_request(0, 0, 0, 8'h00);
      send_request(1, 0, 0, 8'hff);     // unchanged write leaves the cache entry as it is
      send_request(1, 767, 1023, 8'h02); // masked to one bit on write-back
      send_request(0, 767, 1023, 8'h00);
      send_request(0, 768, 0, 8'h00);   // row out of range
      send_request(0, 0, 1024, 8'h00);  // column out of range
      send_request(1, 4095, 4095, 8'haa);
      @(negedge clock);
      req_valid <= 0;
      drain();

      // directed: largest image, offset past the store
      write_register(REG_ROW_LENGTH, 4096);
      write_register(REG_ROW_COUNT, 4096);
      write_register(REG_PACK_SHIFT, 0);
      send_request(1, 255, 4095, 8'h5a); // last pixel of the store
      send_request(0, 255, 4095, 8'h00);
      send_request(0, 256, 0, 8'h00);    // offset reaches the store size
      send_request(1, 4095, 4095, 8'h11);
      send_request(1, 0, 4032, 8'hc3);
      @(negedge clock);
      req_valid <= 0;
      drain();

      // directed: smallest image
      write_register(REG_ROW_LENGTH, 1);
      write_register(REG_ROW_COUNT, 1);
      write_register(REG_PACK_SHIFT, 1);
      send_request(1, 0, 0, 8'h3c);
      send_request(0, 0, 0, 8'h00);
      send_request(0, 1, 0, 8'h00);
      send_request(0, 0, 1, 8'h00);
      @(negedge clock);
      req_valid <= 0;
      drain();

      // random phases across geometries and packing widths
      write_register(REG_ROW_LENGTH, 32);
      write_register(REG_ROW_COUNT, 32);
      write_register(REG_PACK_SHIFT, 0);
      random_burst(330);
      drain();
      write_register(REG_ROW_LENGTH, 100);
      write_register(REG_ROW_COUNT, 60);
      write_register(REG_PACK_SHIFT, 1);
      random_burst(330);
      drain();
      // repack without flushing: resident blocks are written back at the new width
      write_register(REG_PACK_SHIFT, 2);
      random_burst(330);
      drain();
      write_register(REG_ROW_LENGTH, 4096);
      write_register(REG_ROW_COUNT, 4096);
      write_register(REG_PACK_SHIFT, 3);
      random_burst(330);
      drain();
      write_register(REG_ROW_LENGTH, 1);
      write_register(REG_ROW_COUNT, 4096);
      write_register(REG_PACK_SHIFT, 0);
      random_burst(330);

      while (board.awaited.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
